[rtl/core/wmmd_pkg.sv]
// ----------------------------------------------------------------------------
// wmmd_pkg: shared constants and types for the min/max waveform decimator
// Field widths, register codes, reset values and divider handshake structs.
// ----------------------------------------------------------------------------
package wmmd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COORD_BITS  = 12;
  localparam int COUNT_BITS  = 24;

  localparam int SPAN_BITS   = 12;
  localparam int VIEW_BITS   = 24;
  localparam int MID_BITS    = 11;
  localparam int GAIN_BITS   = 15;
  localparam int GAIN_FRAC   = 15;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  localparam logic [CFG_IDX_BITS-1:0] REG_PIXEL_SPAN      = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLES_IN_VIEW = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MID_HEIGHT      = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_AMPLITUDE_GAIN  = 2'd3;

  localparam logic [SPAN_BITS-1:0] RST_PIXEL_SPAN      = SPAN_BITS'(510);
  localparam logic [VIEW_BITS-1:0] RST_SAMPLES_IN_VIEW = VIEW_BITS'(1024);
  localparam logic [MID_BITS-1:0]  RST_MID_HEIGHT      = MID_BITS'(128);
  localparam logic [GAIN_BITS-1:0] RST_AMPLITUDE_GAIN  = GAIN_BITS'(29491);

  localparam int Y_SHIFT   = SAMPLE_BITS - 1 + GAIN_FRAC;
  localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + MID_BITS;
  localparam int MULB_BITS = ((GAIN_BITS > MID_BITS) ? GAIN_BITS : MID_BITS) + 1;
  localparam int NUM_BITS  = ((PROD_BITS + 2) > (Y_SHIFT + COORD_BITS + 2)) ?
                             (PROD_BITS + 2) : (Y_SHIFT + COORD_BITS + 2);
  localparam int CMP_BITS  = ((COUNT_BITS > VIEW_BITS) ? COUNT_BITS : VIEW_BITS) + 1;
  localparam int DIV_CNT_BITS = $clog2(SPAN_BITS + 1);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0]         COUNT_MAX  = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic                 start;
    logic [SPAN_BITS-1:0] dividend;
    logic [VIEW_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [SPAN_BITS-1:0] quotient;
    logic [VIEW_BITS-1:0] remainder;
  } div_rsp_t;

endpackage

[rtl/core/wmmd_divider.sv]
// ----------------------------------------------------------------------------
// wmmd_divider: iterative restoring divider
// One quotient bit per cycle; gives span / view and span % view.
// ----------------------------------------------------------------------------
module wmmd_divider (
  input  logic               clk,
  input  logic               rst,
  input  wmmd_pkg::div_req_t req,
  output wmmd_pkg::div_rsp_t rsp
);
  import wmmd_pkg::*;

  logic [SPAN_BITS-1:0]    dq;
  logic [VIEW_BITS-1:0]    rem;
  logic [VIEW_BITS-1:0]    dvs;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic                    done;
  logic [VIEW_BITS:0]      trial;
  logic                    ge;

  assign trial = {rem, dq[SPAN_BITS-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= DIV_CNT_BITS'(SPAN_BITS);
      end else if (cnt != '0) begin
        cnt <= cnt - DIV_CNT_BITS'(1);
        if (cnt == DIV_CNT_BITS'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq  <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (cnt != '0) begin
      rem <= ge ? VIEW_BITS'(trial - {1'b0, dvs}) : trial[VIEW_BITS-1:0];
      dq  <= {dq[SPAN_BITS-2:0], ge};
    end
  end

  assign rsp.busy      = cnt != '0;
  assign rsp.done      = done;
  assign rsp.quotient  = dq;
  assign rsp.remainder = rem;

endmodule

[rtl/core/waveform_min_max_decimator.sv]
// ----------------------------------------------------------------------------
// waveform_min_max_decimator: min/max decimation of samples into segments
// Tracks column min/max per pixel and emits vertical and joining segments.
//
//   channel  direction  handshake           payload
//   in       to block   in_valid/in_stall   sample, trace_start
//   out      from block out_valid/out_stall x_from, y_from, x_to, y_to,
//                                           last_segment
//   cfg      to block   cfg_we              cfg_index, cfg_data
//
// A sample that stays in its column passes through S_UPD only; a column change
// also runs S_MA, S_MB and S_FIN for each row in the one shared multiplier,
// 2 rows (joining segment only) or 4 rows (with min/max segment), then emits
// each segment in S_EMIT. A trace-start item waits for the bit-serial divider.
// Reset is synchronous; in_stall is high while an item is in work, and a
// finished segment waits in the output register while out_stall is high.
// ----------------------------------------------------------------------------
module waveform_min_max_decimator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [wmmd_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                 trace_start,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [wmmd_pkg::COORD_BITS-1:0]      x_from,
  output logic [wmmd_pkg::COORD_BITS-1:0]      y_from,
  output logic [wmmd_pkg::COORD_BITS-1:0]      x_to,
  output logic [wmmd_pkg::COORD_BITS-1:0]      y_to,
  output logic                                 last_segment,
  input  logic                                 cfg_we,
  input  logic [wmmd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [wmmd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import wmmd_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_UPD  = 7'b0000100,
    S_MA   = 7'b0001000,
    S_MB   = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  localparam logic [1:0] ROW_MIN  = 2'd0;
  localparam logic [1:0] ROW_MAX  = 2'd1;
  localparam logic [1:0] ROW_PREV = 2'd2;
  localparam logic [1:0] ROW_CUR  = 2'd3;

  state_t state;

  logic [SPAN_BITS-1:0] pixel_span;
  logic [VIEW_BITS-1:0] samples_in_view;
  logic [MID_BITS-1:0]  mid_height;
  logic [GAIN_BITS-1:0] amplitude_gain;

  logic signed [SAMPLE_BITS-1:0] previous_sample;
  logic signed [SAMPLE_BITS-1:0] column_minimum;
  logic signed [SAMPLE_BITS-1:0] column_maximum;
  logic [COUNT_BITS-1:0]         column_sample_count;
  logic [COORD_BITS-1:0]         column_position;
  logic [COUNT_BITS-1:0]         position_remainder;
  logic [COORD_BITS-1:0]         step_quotient;
  logic [COUNT_BITS-1:0]         step_remainder;

  logic signed [SAMPLE_BITS-1:0] cur;
  logic signed [SAMPLE_BITS-1:0] seg_val [4];
  logic [COORD_BITS-1:0]         y_row [4];
  logic [1:0]                    idx;
  logic                          vert;
  logic                          emit_first;
  logic [COORD_BITS-1:0]         x_left;
  logic [COORD_BITS-1:0]         x_right;
  logic signed [PROD_BITS-1:0]   prod;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                          in_acc;
  logic                          out_free;
  logic [VIEW_BITS-1:0]          n_eff;
  logic signed [SAMPLE_BITS-1:0] mn_a, mn_b, mx_a, mx_b;
  logic [COUNT_BITS-1:0]         cnt_inc;
  logic [CMP_BITS-1:0]           rem_sum;
  logic                          carry;
  logic [COUNT_BITS-1:0]         rem_new;
  logic                          advance_nz;
  logic [COORD_BITS-1:0]         x_next;

  logic signed [PROD_BITS-1:0]           mul_a;
  logic signed [MULB_BITS-1:0]           mul_b;
  logic signed [PROD_BITS+MULB_BITS-1:0] mul_p;
  logic signed [NUM_BITS-1:0]            num;
  logic [NUM_BITS-Y_SHIFT-1:0]           yq;
  logic [COORD_BITS-1:0]                 y_sat;

  assign in_stall = state != S_IDLE;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign n_eff    = (samples_in_view == '0) ? VIEW_BITS'(1) : samples_in_view;

  assign div_req.start    = in_acc && trace_start;
  assign div_req.dividend = pixel_span;
  assign div_req.divisor  = n_eff;

  wmmd_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Column statistics and position step
  always_comb begin
    mn_a       = (previous_sample < column_minimum) ? previous_sample : column_minimum;
    mn_b       = (cur < mn_a) ? cur : mn_a;
    mx_a       = (previous_sample > column_maximum) ? previous_sample : column_maximum;
    mx_b       = (cur > mx_a) ? cur : mx_a;
    cnt_inc    = (column_sample_count < COUNT_MAX) ?
                 column_sample_count + COUNT_BITS'(1) : column_sample_count;
    rem_sum    = CMP_BITS'(position_remainder) + CMP_BITS'(step_remainder);
    carry      = rem_sum >= CMP_BITS'(n_eff);
    rem_new    = carry ? COUNT_BITS'(rem_sum - CMP_BITS'(n_eff)) : COUNT_BITS'(rem_sum);
    advance_nz = (step_quotient != '0) || carry;
    x_next     = column_position + step_quotient + COORD_BITS'(carry);
  end

  // Shared multiplier: sample times gain, then times mid height
  always_comb begin
    case (state)
      S_MB: begin
        mul_a = prod;
        mul_b = MULB_BITS'(mid_height);
      end
      default: begin
        mul_a = PROD_BITS'(seg_val[idx]);
        mul_b = MULB_BITS'(amplitude_gain);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Row from product: mid minus scaled value, clamped to the coordinate range
  always_comb begin
    num = NUM_BITS'({1'b0, mid_height, {Y_SHIFT{1'b0}}}) - NUM_BITS'(prod);
    yq  = num[NUM_BITS-1:Y_SHIFT];
    if (num[NUM_BITS-1]) begin
      y_sat = '0;
    end else if ((yq >> COORD_BITS) != '0) begin
      y_sat = '1;
    end else begin
      y_sat = yq[COORD_BITS-1:0];
    end
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      pixel_span          <= RST_PIXEL_SPAN;
      samples_in_view     <= RST_SAMPLES_IN_VIEW;
      mid_height          <= RST_MID_HEIGHT;
      amplitude_gain      <= RST_AMPLITUDE_GAIN;
      previous_sample     <= '0;
      column_minimum      <= SAMPLE_MAX;
      column_maximum      <= SAMPLE_MIN;
      column_sample_count <= '0;
      column_position     <= '0;
      position_remainder  <= '0;
      step_quotient       <= '0;
      step_remainder      <= '0;
      out_valid           <= 1'b0;
      idx                 <= ROW_MIN;
      vert                <= 1'b0;
      emit_first          <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PIXEL_SPAN:      pixel_span      <= cfg_data[SPAN_BITS-1:0];
          REG_SAMPLES_IN_VIEW: samples_in_view <= cfg_data[VIEW_BITS-1:0];
          REG_MID_HEIGHT:      mid_height      <= cfg_data[MID_BITS-1:0];
          REG_AMPLITUDE_GAIN:  amplitude_gain  <= cfg_data[GAIN_BITS-1:0];
          default: ;
        endcase
      end

      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (trace_start) begin
              column_position     <= '0;
              position_remainder  <= '0;
              column_minimum      <= SAMPLE_MAX;
              column_maximum      <= SAMPLE_MIN;
              column_sample_count <= '0;
              previous_sample     <= sample;
              state               <= S_DIV;
            end else begin
              state <= S_UPD;
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            step_quotient  <= COORD_BITS'(div_rsp.quotient);
            step_remainder <= COUNT_BITS'(div_rsp.remainder);
            state          <= S_IDLE;
          end
        end
        S_UPD: begin
          column_position    <= x_next;
          position_remainder <= rem_new;
          previous_sample    <= cur;
          if (advance_nz) begin
            column_minimum      <= SAMPLE_MAX;
            column_maximum      <= SAMPLE_MIN;
            column_sample_count <= '0;
            vert                <= cnt_inc > COUNT_BITS'(1);
            idx                 <= (cnt_inc > COUNT_BITS'(1)) ? ROW_MIN : ROW_PREV;
            state               <= S_MA;
          end else begin
            column_minimum      <= mn_b;
            column_maximum      <= mx_b;
            column_sample_count <= cnt_inc;
            state               <= S_IDLE;
          end
        end
        S_MA: begin
          state <= S_MB;
        end
        S_MB: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (idx == ROW_CUR) begin
            emit_first <= vert;
            state      <= S_EMIT;
          end else begin
            idx   <= idx + 2'(1);
            state <= S_MA;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (emit_first) begin
              emit_first <= 1'b0;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur <= sample;
    end
    if (state == S_UPD) begin
      seg_val[ROW_MIN]  <= mn_b;
      seg_val[ROW_MAX]  <= mx_b;
      seg_val[ROW_PREV] <= previous_sample;
      seg_val[ROW_CUR]  <= cur;
      x_left            <= column_position;
      x_right           <= x_next;
    end
    if (state == S_MA || state == S_MB) begin
      prod <= mul_p[PROD_BITS-1:0];
    end
    if (state == S_FIN) begin
      y_row[idx] <= y_sat;
    end
    if (state == S_EMIT && out_free) begin
      x_from <= x_left;
      if (emit_first) begin
        y_from       <= y_row[ROW_MIN];
        x_to         <= x_left;
        y_to         <= y_row[ROW_MAX];
        last_segment <= 1'b0;
      end else begin
        y_from       <= y_row[ROW_PREV];
        x_to         <= x_right;
        y_to         <= y_row[ROW_CUR];
        last_segment <= 1'b1;
      end
    end
  end

  a_vertical_same_column: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_segment |-> x_from == x_to)
    else $error("min/max segment spans two columns");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    state != S_DIV |-> !div_rsp.busy)
    else $error("divider busy outside divide phase");

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT))
    else $error("segment loaded outside emit phase");

  a_column_cleared: assert property (@(posedge clk) disable iff (rst)
    state == S_MA |-> column_sample_count == '0)
    else $error("column statistics not cleared on column change");

endmodule
